// File: design/drm_pkg.sv
// Package for the dirty rectangle merge list.
// Holds the rectangle type, sizing constants, status codes and geometry helpers.
// No dependencies.
package drm_pkg;

  localparam int MAX_RECTS  = 16;
  localparam int COORD_BITS = 16;
  localparam int COORD_W    = 16;
  localparam int CAP_W      = 5;
  localparam int HELD_W     = 5;
  localparam int IDX_W      = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W      = $clog2(MAX_RECTS + 1);
  localparam int SPAN_W     = COORD_W + 2;
  localparam int AREA_W     = 2 * SPAN_W;
  localparam int GROWTH_W   = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] l;
    logic signed [COORD_W-1:0] t;
    logic signed [COORD_W-1:0] r;
    logic signed [COORD_W-1:0] b;
  } rect_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FLUSHED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_WRITE = 2'd2
  } cell_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_GROW_END,
    S_DROP,
    S_APPEND,
    S_RESP,
    S_FLUSH
  } state_e;

  // Control from the sequencer to the growth evaluator
  typedef struct packed {
    logic clear;
    logic valid;
  } grow_ctl_t;

  // Keep the low COORD_BITS bits and sign extend
  function automatic logic signed [COORD_W-1:0] sext_coord(logic [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] s;
    s = signed'(v << (COORD_W - COORD_BITS));
    return s >>> (COORD_W - COORD_BITS);
  endfunction

  function automatic logic signed [SPAN_W-1:0] ext_coord(logic signed [COORD_W-1:0] v);
    return {{(SPAN_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  // Overlap or zero-pixel gap on both axes
  function automatic logic rects_touch(rect_t a, rect_t c);
    return (ext_coord(a.l) <= ext_coord(c.r) + SPAN_W'(1)) &&
           (ext_coord(c.l) <= ext_coord(a.r) + SPAN_W'(1)) &&
           (ext_coord(a.t) <= ext_coord(c.b) + SPAN_W'(1)) &&
           (ext_coord(c.t) <= ext_coord(a.b) + SPAN_W'(1));
  endfunction

  function automatic rect_t rect_union(rect_t a, rect_t c);
    rect_t u;
    u = a;
    if (c.l < a.l) u.l = c.l;
    if (c.t < a.t) u.t = c.t;
    if (c.r > a.r) u.r = c.r;
    if (c.b > a.b) u.b = c.b;
    return u;
  endfunction

  // Signed area; width and height may be negative for reversed rectangles
  function automatic logic signed [AREA_W-1:0] rect_area(rect_t a);
    logic signed [SPAN_W-1:0] w;
    logic signed [SPAN_W-1:0] h;
    logic signed [AREA_W-1:0] p;
    w = ext_coord(a.r) - ext_coord(a.l) + SPAN_W'(1);
    h = ext_coord(a.b) - ext_coord(a.t) + SPAN_W'(1);
    p = AREA_W'(w) * AREA_W'(h);
    return p;
  endfunction

endpackage

// File: design/dirty_rect_merge_list_top.sv
// Dirty rectangle merge list, top level: sequencer, rectangle chain, output register.
// Add: touch scan of n entries, append, load; a full list adds a growth scan of n,
// compare, drop and a second scan of n - 1, n counted after the first scan. The chain
// shifts one slot a cycle, held while a flush waits on a stalled output.
// Flush: one result per cycle while the output is not stalled. Input stalls until an
// item's last result is loaded. Reset (rst_ni low, async) empties list, capacity MAX_RECTS.
module dirty_rect_merge_list_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drm_pkg::CAP_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic signed [drm_pkg::COORD_W-1:0]  left_x_i,
  input  logic signed [drm_pkg::COORD_W-1:0]  top_y_i,
  input  logic signed [drm_pkg::COORD_W-1:0]  right_x_i,
  input  logic signed [drm_pkg::COORD_W-1:0]  bottom_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [drm_pkg::COORD_W-1:0]  out_left_o,
  output logic signed [drm_pkg::COORD_W-1:0]  out_top_o,
  output logic signed [drm_pkg::COORD_W-1:0]  out_right_o,
  output logic signed [drm_pkg::COORD_W-1:0]  out_bottom_o,
  output logic [drm_pkg::HELD_W-1:0]          entries_held_o,
  output logic                                last_o
);

  drm_pkg::state_e              state_q, state_d;
  logic [drm_pkg::CAP_W-1:0]    cap_cfg_q;
  logic [drm_pkg::CNT_W-1:0]    count_q, count_d;
  logic [drm_pkg::CNT_W-1:0]    n_q, n_d;
  logic [drm_pkg::CNT_W-1:0]    k_q, k_d;
  logic [drm_pkg::CNT_W-1:0]    len_q, len_d;
  logic                         pass2_q, pass2_d;
  drm_pkg::rect_t               m_q, m_d;
  drm_pkg::status_e             pend_st_q, pend_st_d;
  drm_pkg::rect_t               pend_rect_q, pend_rect_d;
  logic [drm_pkg::CNT_W-1:0]    pend_held_q, pend_held_d;

  logic                         out_valid_q;
  drm_pkg::status_e             out_st_q;
  drm_pkg::rect_t               out_rect_q;
  logic [drm_pkg::CNT_W-1:0]    out_held_q;
  logic                         out_last_q;
  logic                         out_load;
  drm_pkg::status_e             load_st;
  drm_pkg::rect_t               load_rect;
  logic [drm_pkg::CNT_W-1:0]    load_held;
  logic                         load_last;

  drm_pkg::rect_t               cell_rect [drm_pkg::MAX_RECTS];
  drm_pkg::cell_op_e            cell_op   [drm_pkg::MAX_RECTS];
  drm_pkg::rect_t               wr_rect;
  drm_pkg::rect_t               head;
  logic                         head_touch;
  logic                         slot_free;
  logic                         in_acc;
  logic [drm_pkg::CNT_W-1:0]    cap;
  logic                         keep_w;
  logic [drm_pkg::CNT_W-1:0]    keep_pos;
  logic                         shift_all;
  logic                         drop_en;
  logic                         append_en;
  drm_pkg::grow_ctl_t           grow_ctl;
  logic [drm_pkg::IDX_W-1:0]    best_idx;
  drm_pkg::rect_t               best_rect;
  drm_pkg::rect_t               in_rect;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != drm_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign head        = cell_rect[0];
  assign head_touch  = drm_pkg::rects_touch(m_q, head);

  assign in_rect.l = drm_pkg::sext_coord(left_x_i);
  assign in_rect.t = drm_pkg::sext_coord(top_y_i);
  assign in_rect.r = drm_pkg::sext_coord(right_x_i);
  assign in_rect.b = drm_pkg::sext_coord(bottom_y_i);

  // Saturate capacity to the built depth
  always_comb begin
    if (int'(cap_cfg_q) > drm_pkg::MAX_RECTS) begin
      cap = drm_pkg::CNT_W'(drm_pkg::MAX_RECTS);
    end else begin
      cap = drm_pkg::CNT_W'(cap_cfg_q);
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_cfg_q <= drm_pkg::CAP_W'(drm_pkg::MAX_RECTS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_cfg_q <= cfg_data_i;
    end
  end

  // Next state
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    k_d         = k_q;
    len_d       = len_q;
    pass2_d     = pass2_q;
    m_d         = m_q;
    pend_st_d   = pend_st_q;
    pend_rect_d = pend_rect_q;
    pend_held_d = pend_held_q;
    case (state_q)
      drm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (op_i == drm_pkg::OP_FLUSH) begin
            if (count_q == '0) begin
              pend_st_d   = drm_pkg::ST_EMPTY;
              pend_rect_d = '0;
              pend_held_d = '0;
              state_d     = drm_pkg::S_RESP;
            end else begin
              state_d = drm_pkg::S_FLUSH;
            end
          end else if (cap == '0 || count_q > cap) begin
            pend_st_d   = drm_pkg::ST_IGNORED;
            pend_rect_d = '0;
            pend_held_d = count_q;
            state_d     = drm_pkg::S_RESP;
          end else begin
            m_d     = in_rect;
            n_d     = count_q;
            len_d   = count_q;
            k_d     = '0;
            pass2_d = 1'b0;
            state_d = (count_q == '0) ? drm_pkg::S_APPEND : drm_pkg::S_SCAN;
          end
        end
      end
      drm_pkg::S_SCAN: begin
        if (head_touch) begin
          m_d   = drm_pkg::rect_union(m_q, head);
          len_d = len_q - drm_pkg::CNT_W'(1);
        end
        k_d = k_q + drm_pkg::CNT_W'(1);
        if (k_q == n_q - drm_pkg::CNT_W'(1)) begin
          count_d = len_d;
          k_d     = '0;
          n_d     = len_d;
          if (!pass2_q && len_d >= cap && len_d != '0) begin
            state_d = drm_pkg::S_GROW;
          end else begin
            state_d = drm_pkg::S_APPEND;
          end
        end
      end
      drm_pkg::S_GROW: begin
        k_d = k_q + drm_pkg::CNT_W'(1);
        if (k_q == n_q - drm_pkg::CNT_W'(1)) begin
          state_d = drm_pkg::S_GROW_END;
        end
      end
      drm_pkg::S_GROW_END: begin
        state_d = drm_pkg::S_DROP;
      end
      drm_pkg::S_DROP: begin
        m_d     = drm_pkg::rect_union(m_q, best_rect);
        count_d = count_q - drm_pkg::CNT_W'(1);
        n_d     = count_d;
        len_d   = count_d;
        k_d     = '0;
        pass2_d = 1'b1;
        state_d = (count_d == '0) ? drm_pkg::S_APPEND : drm_pkg::S_SCAN;
      end
      drm_pkg::S_APPEND: begin
        if (count_q < drm_pkg::CNT_W'(drm_pkg::MAX_RECTS)) begin
          count_d = count_q + drm_pkg::CNT_W'(1);
        end
        pend_st_d   = drm_pkg::ST_ADDED;
        pend_rect_d = m_q;
        pend_held_d = count_d;
        state_d     = drm_pkg::S_RESP;
      end
      drm_pkg::S_RESP: begin
        if (slot_free) state_d = drm_pkg::S_IDLE;
      end
      drm_pkg::S_FLUSH: begin
        if (slot_free) begin
          count_d = count_q - drm_pkg::CNT_W'(1);
          if (count_q == drm_pkg::CNT_W'(1)) state_d = drm_pkg::S_IDLE;
        end
      end
      default: state_d = drm_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: chain commands, evaluator control, result load
  always_comb begin
    keep_w    = 1'b0;
    keep_pos  = len_q - drm_pkg::CNT_W'(1);
    shift_all = 1'b0;
    drop_en   = 1'b0;
    append_en = 1'b0;
    wr_rect   = head;
    grow_ctl  = '0;
    out_load  = 1'b0;
    load_st   = pend_st_q;
    load_rect = pend_rect_q;
    load_held = pend_held_q;
    load_last = 1'b1;
    case (state_q)
      drm_pkg::S_IDLE: begin
        grow_ctl.clear = 1'b1;
      end
      drm_pkg::S_SCAN: begin
        shift_all = 1'b1;
        keep_w    = !head_touch;
      end
      drm_pkg::S_GROW: begin
        shift_all      = 1'b1;
        keep_w         = 1'b1;
        grow_ctl.valid = 1'b1;
      end
      drm_pkg::S_DROP: begin
        drop_en = 1'b1;
      end
      drm_pkg::S_APPEND: begin
        append_en = 1'b1;
        wr_rect   = m_q;
        keep_pos  = count_q;
      end
      drm_pkg::S_RESP: begin
        out_load = slot_free;
      end
      drm_pkg::S_FLUSH: begin
        out_load  = slot_free;
        shift_all = slot_free;
        load_st   = drm_pkg::ST_FLUSHED;
        load_rect = head;
        load_held = count_q - drm_pkg::CNT_W'(1);
        load_last = (count_q == drm_pkg::CNT_W'(1));
      end
      default: ;
    endcase
  end

  // Per-cell commands
  always_comb begin
    for (int i = 0; i < drm_pkg::MAX_RECTS; i++) begin
      cell_op[i] = drm_pkg::CELL_HOLD;
      if (shift_all) cell_op[i] = drm_pkg::CELL_SHIFT;
      if (drop_en && drm_pkg::IDX_W'(i) >= best_idx) cell_op[i] = drm_pkg::CELL_SHIFT;
      if ((keep_w || append_en) && drm_pkg::CNT_W'(i) == keep_pos) begin
        cell_op[i] = drm_pkg::CELL_WRITE;
      end
    end
  end

  // Rectangle chain
  for (genvar g = 0; g < drm_pkg::MAX_RECTS; g++) begin : g_cell
    drm_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op[g]),
      .upper_i   (cell_rect[(g + 1 < drm_pkg::MAX_RECTS) ? g + 1 : g]),
      .wr_rect_i (wr_rect),
      .rect_o    (cell_rect[g])
    );
  end

  drm_grow_eval u_grow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (grow_ctl),
    .merged_i    (m_q),
    .entry_i     (head),
    .idx_i       (k_q[drm_pkg::IDX_W-1:0]),
    .best_idx_o  (best_idx),
    .best_rect_o (best_rect)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drm_pkg::S_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
      len_q       <= '0;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      k_q     <= k_d;
      len_q   <= len_d;
      pass2_q <= pass2_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_q         <= m_d;
    pend_st_q   <= pend_st_d;
    pend_rect_q <= pend_rect_d;
    pend_held_q <= pend_held_d;
    if (out_load) begin
      out_st_q   <= load_st;
      out_rect_q <= load_rect;
      out_held_q <= load_held;
      out_last_q <= load_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_left_o     = out_rect_q.l;
  assign out_top_o      = out_rect_q.t;
  assign out_right_o    = out_rect_q.r;
  assign out_bottom_o   = out_rect_q.b;
  assign entries_held_o = drm_pkg::HELD_W'(out_held_q);
  assign last_o         = out_last_q;

endmodule

// File: design/drm_cell.sv
// One slot of the rectangle chain.
// Holds a rectangle and takes its upper neighbor's or the write data on command.
// Depends on drm_pkg.
module drm_cell (
  input  logic              clk_i,
  input  drm_pkg::cell_op_e op_i,
  input  drm_pkg::rect_t    upper_i,
  input  drm_pkg::rect_t    wr_rect_i,
  output drm_pkg::rect_t    rect_o
);

  drm_pkg::rect_t rect_q;
  drm_pkg::rect_t rect_d;

  // Select the next content
  always_comb begin
    case (op_i)
      drm_pkg::CELL_SHIFT: rect_d = upper_i;
      drm_pkg::CELL_WRITE: rect_d = wr_rect_i;
      default:             rect_d = rect_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  assign rect_o = rect_q;

endmodule

// File: design/drm_grow_eval.sv
// Least-growth search over the entries passing the chain head.
// Stage one forms the three areas, stage two keeps the smallest growth.
// Depends on drm_pkg.
module drm_grow_eval (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  drm_pkg::grow_ctl_t        ctl_i,
  input  drm_pkg::rect_t            merged_i,
  input  drm_pkg::rect_t            entry_i,
  input  logic [drm_pkg::IDX_W-1:0] idx_i,
  output logic [drm_pkg::IDX_W-1:0] best_idx_o,
  output drm_pkg::rect_t            best_rect_o
);

  logic                                v1_q;
  logic [drm_pkg::IDX_W-1:0]           idx1_q;
  drm_pkg::rect_t                      rect1_q;
  logic signed [drm_pkg::AREA_W-1:0]   pc_q;
  logic signed [drm_pkg::AREA_W-1:0]   pe_q;
  logic signed [drm_pkg::AREA_W-1:0]   pm_q;
  logic [drm_pkg::GROWTH_W-1:0]        best_g_q;
  logic [drm_pkg::GROWTH_W-1:0]        best_g_d;
  logic [drm_pkg::IDX_W-1:0]           best_idx_q;
  logic [drm_pkg::IDX_W-1:0]           best_idx_d;
  drm_pkg::rect_t                      best_rect_q;
  drm_pkg::rect_t                      best_rect_d;
  logic [drm_pkg::GROWTH_W-1:0]        growth;

  // Stage one: areas of the union, the entry and the merged rectangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= idx_i;
    rect1_q <= entry_i;
    pc_q    <= drm_pkg::rect_area(drm_pkg::rect_union(merged_i, entry_i));
    pe_q    <= drm_pkg::rect_area(entry_i);
    pm_q    <= drm_pkg::rect_area(merged_i);
  end

  // Stage two: growth modulo 2^64, strict compare keeps the lowest index;
  // the first entry always seeds the search so its rectangle is captured
  always_comb begin
    growth = {{(drm_pkg::GROWTH_W - drm_pkg::AREA_W){pc_q[drm_pkg::AREA_W-1]}}, pc_q}
           - {{(drm_pkg::GROWTH_W - drm_pkg::AREA_W){pm_q[drm_pkg::AREA_W-1]}}, pm_q}
           - {{(drm_pkg::GROWTH_W - drm_pkg::AREA_W){pe_q[drm_pkg::AREA_W-1]}}, pe_q};
    best_g_d    = best_g_q;
    best_idx_d  = best_idx_q;
    best_rect_d = best_rect_q;
    if (ctl_i.clear) begin
      best_g_d   = '1;
      best_idx_d = '0;
    end else if (v1_q && ((growth < best_g_q) || (idx1_q == '0))) begin
      best_g_d    = growth;
      best_idx_d  = idx1_q;
      best_rect_d = rect1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    best_g_q    <= best_g_d;
    best_idx_q  <= best_idx_d;
    best_rect_q <= best_rect_d;
  end

  assign best_idx_o  = best_idx_q;
  assign best_rect_o = best_rect_q;

endmodule

// File: design/drm_checker.sv
// Port-level checks for the dirty rectangle merge list.
// Bound to dirty_rect_merge_list_top; depends on drm_pkg.
module drm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [1:0]                         status_o,
  input logic signed [drm_pkg::COORD_W-1:0] out_left_o,
  input logic [drm_pkg::HELD_W-1:0]         entries_held_o,
  input logic                               last_o
);

  // Stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_left_o) && $stable(status_o))
    else $error("stalled output item changed");

  // Only a flush produces more than one item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == drm_pkg::ST_FLUSHED && entries_held_o != '0)
    else $error("non-final item is not a flushed entry");

  // An add leaves at least one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == drm_pkg::ST_ADDED |-> entries_held_o != '0)
    else $error("add reports empty list");

  // Flush of an empty list reports nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == drm_pkg::ST_EMPTY |-> entries_held_o == '0 && last_o)
    else $error("empty flush malformed");

endmodule

bind dirty_rect_merge_list_top drm_checker u_drm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_left_o     (out_left_o),
  .entries_held_o (entries_held_o),
  .last_o         (last_o)
);
